[design/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, register indexes and constants for the LED flicker sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfs_pkg;

    // Widths of the fixed fields
    localparam int LFSR_W    = 16;
    localparam int LEVEL_W   = 8;
    localparam int TICKS_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_LOW_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_UNIT    = 3'd5;

    // Reset values
    localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL     = 8'd40;
    localparam logic [LEVEL_W-1:0] RST_ALT_LOW_LEVEL = 8'd20;
    localparam logic [TICKS_W-1:0] RST_STEP_TICKS    = 16'd60;
    localparam logic [TICKS_W-1:0] RST_HOLD_TICKS    = 16'd150;
    localparam logic [TICKS_W-1:0] RST_PAUSE_UNIT    = 16'd1000;
    localparam logic [LFSR_W-1:0]  LFSR_SEED         = 16'd10;

    // Duty levels at the turning points
    localparam logic [LEVEL_W-1:0] LEVEL_TOP     = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_ALT_TOP = 8'd254;

    // Sequence phases
    typedef enum logic [1:0] {
        PH_RISE   = 2'd0,
        PH_HOLD   = 2'd1,
        PH_RETURN = 2'd2,
        PH_PAUSE  = 2'd3
    } t_phase;

    // Configuration registers
    typedef struct packed {
        logic               alt_mode;
        logic [LEVEL_W-1:0] low_level;
        logic [LEVEL_W-1:0] alt_low_level;
        logic [TICKS_W-1:0] step_ticks;
        logic [TICKS_W-1:0] hold_ticks;
        logic [TICKS_W-1:0] pause_unit_ticks;
    } t_cfg;

    // One LFSR shift, taps 16,15,13,4; an all-zero value restarts at one
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W-1:0] v;
        logic              fb;
        v  = (cur == '0) ? LFSR_W'(1) : cur;
        fb = v[15] ^ v[14] ^ v[12] ^ v[3];
        return {v[LFSR_W-2:0], fb};
    endfunction

endpackage

`default_nettype wire

[design/lfs_pause_mod.sv]
// ----------------------------------------------------------------------------
// lfs_pause_mod
// Precomputes the next LFSR value and its remainder by the pause modulus,
// so the pause length is ready before the sequencer needs it.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_pause_mod #(
    parameter int PAUSE_MODULUS = 128
) (
    input  wire logic                               i_clk,
    input  wire logic [lfs_pkg::LFSR_W-1:0]         i_lfsr,
    output logic      [lfs_pkg::LFSR_W-1:0]         o_lfsr_next,
    output logic      [$clog2(PAUSE_MODULUS)-1:0]   o_units
);
    import lfs_pkg::*;

    localparam int PW      = $clog2(PAUSE_MODULUS);
    localparam int SHIFT   = LFSR_W + PW;
    localparam int RECIP_W = LFSR_W + 2;
    localparam int PROD_W  = LFSR_W + RECIP_W;
    // ceil(2^SHIFT / modulus) gives an exact quotient for every 16-bit value
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(PAUSE_MODULUS) - 64'd1) / 64'(PAUSE_MODULUS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [LFSR_W-1:0]  MOD_C = LFSR_W'(PAUSE_MODULUS);

    logic [LFSR_W-1:0] r_src;
    logic [PROD_W-1:0] r_prod;
    logic [LFSR_W-1:0] quot;
    logic [LFSR_W-1:0] rem;

    // Next LFSR value
    assign o_lfsr_next = lfsr_next(i_lfsr);

    // Register the reciprocal product
    always_ff @(posedge i_clk) begin
        r_src  <= o_lfsr_next;
        r_prod <= PROD_W'(o_lfsr_next) * PROD_W'(RECIP);
    end

    // Take the remainder from the quotient
    always_comb begin
        quot = LFSR_W'(r_prod >> SHIFT);
        rem  = r_src - LFSR_W'(quot * MOD_C);
    end

    assign o_units = PW'(rem);

endmodule

`default_nettype wire

[design/lfs_seq_core.sv]
// ----------------------------------------------------------------------------
// lfs_seq_core
// Sequence state: phase, duty level, tick counter, pause units and LFSR.
// Gives the state after the current tick for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_seq_core #(
    parameter int PAUSE_MODULUS = 128
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lfs_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_advance,
    input  wire logic [lfs_pkg::LFSR_W-1:0]         i_lfsr_next,
    input  wire logic [$clog2(PAUSE_MODULUS)-1:0]   i_pause_units,
    output logic      [lfs_pkg::LFSR_W-1:0]         o_lfsr,
    output logic      [lfs_pkg::LEVEL_W-1:0]        o_level,
    output lfs_pkg::t_phase                         o_phase
);
    import lfs_pkg::*;

    localparam int PW = $clog2(PAUSE_MODULUS);

    t_phase              r_phase,      n_phase;
    logic [LEVEL_W-1:0]  r_level,      n_level;
    logic [TICKS_W-1:0]  r_count,      n_count;
    logic [PW-1:0]       r_units_left, n_units_left;
    logic [LFSR_W-1:0]   r_lfsr,       n_lfsr;
    logic                r_top_extra,  n_top_extra;
    logic                r_lfsr_moved;

    logic [TICKS_W-1:0]  step;
    logic [TICKS_W-1:0]  cnt_inc;
    logic [PW-1:0]       units_dec;
    logic                go_hold;
    logic                go_ret;
    logic                go_pause;
    logic                go_rise;
    logic                lfsr_step;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_RISE;
            r_level      <= RST_LOW_LEVEL;
            r_count      <= '0;
            r_units_left <= '0;
            r_lfsr       <= LFSR_SEED;
            r_top_extra  <= 1'b0;
            r_lfsr_moved <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_level      <= n_level;
            r_count      <= n_count;
            r_units_left <= n_units_left;
            r_lfsr       <= n_lfsr;
            r_top_extra  <= n_top_extra;
            r_lfsr_moved <= lfsr_step;
        end
    end

    // Next state for one tick
    always_comb begin
        n_phase      = r_phase;
        n_level      = r_level;
        n_count      = r_count;
        n_units_left = r_units_left;
        n_lfsr       = r_lfsr;
        n_top_extra  = r_top_extra;
        go_hold      = 1'b0;
        go_ret       = 1'b0;
        go_pause     = 1'b0;
        go_rise      = 1'b0;
        step         = (i_cfg.step_ticks == '0) ? TICKS_W'(1) : i_cfg.step_ticks;
        cnt_inc      = r_count + TICKS_W'(1);
        units_dec    = r_units_left - PW'(1);

        if (i_advance) begin
            n_count = cnt_inc;
            case (r_phase)
                PH_RISE: begin
                    if (cnt_inc >= step) begin
                        n_count = '0;
                        if (i_cfg.alt_mode) begin
                            if (r_level <= i_cfg.alt_low_level) go_hold = 1'b1;
                            else n_level = r_level - LEVEL_W'(1);
                        end else begin
                            if (r_level == LEVEL_TOP) go_hold = 1'b1;
                            else n_level = r_level + LEVEL_W'(1);
                        end
                    end
                end
                PH_RETURN: begin
                    if (cnt_inc >= step) begin
                        n_count = '0;
                        if (i_cfg.alt_mode) begin
                            if (r_level == LEVEL_ALT_TOP) go_pause = 1'b1;
                            else n_level = r_level + LEVEL_W'(1);
                        end else if (r_top_extra) begin
                            n_top_extra = 1'b0;
                            n_level     = LEVEL_TOP;
                        end else begin
                            if (r_level <= i_cfg.low_level) go_pause = 1'b1;
                            else n_level = r_level - LEVEL_W'(1);
                        end
                    end
                end
                PH_HOLD: begin
                    if (cnt_inc >= i_cfg.hold_ticks) go_ret = 1'b1;
                end
                PH_PAUSE: begin
                    if (i_cfg.pause_unit_ticks == '0 || r_units_left == '0) begin
                        go_rise = 1'b1;
                    end else if (cnt_inc >= i_cfg.pause_unit_ticks) begin
                        n_count      = '0;
                        n_units_left = units_dec;
                        if (units_dec == '0) go_rise = 1'b1;
                    end
                end
                default: begin
                    go_rise = 1'b1;
                end
            endcase
        end

        // Enter hold, or skip straight to the return ramp
        if (go_hold) begin
            n_phase     = PH_HOLD;
            n_count     = '0;
            n_top_extra = 1'b0;
            if (i_cfg.hold_ticks == '0) go_ret = 1'b1;
        end

        // Enter the return ramp
        if (go_ret) begin
            n_phase = PH_RETURN;
            n_count = '0;
            if (i_cfg.alt_mode) begin
                n_top_extra = 1'b0;
                n_level     = i_cfg.alt_low_level - LEVEL_W'(1);
            end else begin
                n_top_extra = 1'b1;
                n_level     = LEVEL_TOP;
            end
        end

        // Enter the random pause, or skip it when empty
        if (go_pause) begin
            n_lfsr       = i_lfsr_next;
            n_phase      = PH_PAUSE;
            n_count      = '0;
            n_top_extra  = 1'b0;
            n_units_left = i_pause_units;
            if (i_pause_units == '0 || i_cfg.pause_unit_ticks == '0) go_rise = 1'b1;
        end

        // Restart the first ramp
        if (go_rise) begin
            n_phase     = PH_RISE;
            n_count     = '0;
            n_top_extra = 1'b0;
            n_level     = i_cfg.alt_mode ? LEVEL_TOP : i_cfg.low_level;
        end

        lfsr_step = go_pause;
    end

    assign o_lfsr  = r_lfsr;
    assign o_level = n_level;
    assign o_phase = n_phase;

`ifndef SYNTHESIS
    // Pause length is precomputed through a register; two LFSR steps in a row would use a stale value
    a_lfsr_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr_moved |-> !lfsr_step)
        else $error("LFSR stepped on two consecutive cycles");

    // LFSR never settles at zero
    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("LFSR reached zero");

    // A pause in progress always has units left
    a_pause_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAUSE |-> r_units_left != '0)
        else $error("pause phase with no units left");

    // Extra top step flag lives only inside the return ramp
    a_top_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top_extra |-> r_phase == PH_RETURN)
        else $error("extra top step outside the return ramp");
`endif

endmodule

`default_nettype wire

[design/led_flicker_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// led_flicker_sequencer_unit
// Flicker sequencer: one timer tick in, one PWM duty level and phase out.
// ----------------------------------------------------------------------------
// Every accepted word carries one tick flag and yields exactly one result
// word with the duty level and phase after that tick. The block takes one
// word per clock cycle while o_stall is low; a word passes an input
// register and then a result register, and waits in the input register
// while the result register holds an untaken word under a stall. The
// next sequencer state is computed combinationally from the input
// register; the pause length is the remainder of the next LFSR value by a
// reciprocal multiply that is registered ahead of use, which suffices
// because the sequence never steps the LFSR again before that product is renewed.
// Configuration is taken on any cycle the write enable is high and acts at
// the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module led_flicker_sequencer_unit #(
    parameter int PAUSE_MODULUS = 128
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Tick channel
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_tick,
    // Result channel
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic      [lfs_pkg::LEVEL_W-1:0]      o_duty,
    output logic      [1:0]                       o_phase,
    // Configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [lfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lfs_pkg::*;

    localparam int PW = $clog2(PAUSE_MODULUS);

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic               r_in_tick;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_duty;
    t_phase             r_phase;

    logic               out_blocked;
    logic               move;
    logic               accept;
    logic [LFSR_W-1:0]  lfsr_cur;
    logic [LFSR_W-1:0]  lfsr_nx;
    logic [PW-1:0]      pause_units;
    logic [LEVEL_W-1:0] nx_level;
    t_phase             nx_phase;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alt_mode         <= 1'b0;
            r_cfg.low_level        <= RST_LOW_LEVEL;
            r_cfg.alt_low_level    <= RST_ALT_LOW_LEVEL;
            r_cfg.step_ticks       <= RST_STEP_TICKS;
            r_cfg.hold_ticks       <= RST_HOLD_TICKS;
            r_cfg.pause_unit_ticks <= RST_PAUSE_UNIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALT_MODE:      r_cfg.alt_mode         <= i_cfg_data[0];
                CFG_LOW_LEVEL:     r_cfg.low_level        <= i_cfg_data[LEVEL_W-1:0];
                CFG_ALT_LOW_LEVEL: r_cfg.alt_low_level    <= i_cfg_data[LEVEL_W-1:0];
                CFG_STEP_TICKS:    r_cfg.step_ticks       <= i_cfg_data[TICKS_W-1:0];
                CFG_HOLD_TICKS:    r_cfg.hold_ticks       <= i_cfg_data[TICKS_W-1:0];
                CFG_PAUSE_UNIT:    r_cfg.pause_unit_ticks <= i_cfg_data[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: advance the input word when the result register is free
    assign out_blocked = r_out_valid && i_stall;
    assign move        = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;
    assign accept      = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_tick <= i_tick;
        end
    end

    // Pause length precompute
    lfs_pause_mod #(
        .PAUSE_MODULUS (PAUSE_MODULUS)
    ) u_pause_mod (
        .i_clk       (i_clk),
        .i_lfsr      (lfsr_cur),
        .o_lfsr_next (lfsr_nx),
        .o_units     (pause_units)
    );

    // Sequencer state
    lfs_seq_core #(
        .PAUSE_MODULUS (PAUSE_MODULUS)
    ) u_seq_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_advance     (move && r_in_tick),
        .i_lfsr_next   (lfsr_nx),
        .i_pause_units (pause_units),
        .o_lfsr        (lfsr_cur),
        .o_level       (nx_level),
        .o_phase       (nx_phase)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_duty  <= nx_level;
            r_phase <= nx_phase;
        end
    end

    assign o_valid = r_out_valid;
    assign o_duty  = r_duty;
    assign o_phase = r_phase;

endmodule

`default_nettype wire

[dv/flicker_sb_pkg.sv]
// ----------------------------------------------------------------------------
// flicker_sb_pkg
// Duty level prediction and result checking for the LED flicker sequencer.
// ----------------------------------------------------------------------------
// The scoreboard keeps its own copy of the sequencer state and registers.
// Every accepted tick word advances that copy and queues the duty and phase
// the block must report. Result words are checked in order against the queue.
// ----------------------------------------------------------------------------
package flicker_sb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::*;

    localparam int PAUSE_MOD = 128;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty;
        logic [1:0]         phase;
    } t_level_word;

    class flicker_scoreboard;
        t_cfg               regs;
        logic [LFSR_W-1:0]  lfsr;
        logic [LEVEL_W-1:0] duty;
        t_phase             phase;
        logic [TICKS_W-1:0] count;
        logic [TICKS_W-1:0] units_left;
        bit                 top_extra;
        t_level_word        expected_levels[$];
        int unsigned        failures;

        function new();
            regs = '{alt_mode: 1'b0, low_level: RST_LOW_LEVEL,
                     alt_low_level: RST_ALT_LOW_LEVEL, step_ticks: RST_STEP_TICKS,
                     hold_ticks: RST_HOLD_TICKS, pause_unit_ticks: RST_PAUSE_UNIT};
            lfsr       = LFSR_SEED;
            duty       = RST_LOW_LEVEL;
            phase      = PH_RISE;
            count      = '0;
            units_left = '0;
            top_extra  = 1'b0;
            failures   = 0;
        endfunction

        // Mirror a register write; only the register's own bits count
        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALT_MODE:      regs.alt_mode         = data[0];
                CFG_LOW_LEVEL:     regs.low_level        = data[LEVEL_W-1:0];
                CFG_ALT_LOW_LEVEL: regs.alt_low_level    = data[LEVEL_W-1:0];
                CFG_STEP_TICKS:    regs.step_ticks       = data;
                CFG_HOLD_TICKS:    regs.hold_ticks       = data;
                CFG_PAUSE_UNIT:    regs.pause_unit_ticks = data;
                default: ;
            endcase
        endfunction

        // Shift the 16-bit LFSR (taps 16,15,13,4), restarting from one when zero
        function logic [LFSR_W-1:0] shift_lfsr();
            logic [LFSR_W-1:0] v;
            v    = (lfsr == '0) ? LFSR_W'(1) : lfsr;
            lfsr = {v[LFSR_W-2:0], v[15] ^ v[14] ^ v[12] ^ v[3]};
            return lfsr;
        endfunction

        function void start_rise();
            phase     = PH_RISE;
            count     = '0;
            top_extra = 1'b0;
            duty      = regs.alt_mode ? LEVEL_TOP : regs.low_level;
        endfunction

        // Normal mode opens the return ramp with one extra step at the top
        function void start_return();
            phase = PH_RETURN;
            count = '0;
            if (regs.alt_mode) begin
                top_extra = 1'b0;
                duty      = regs.alt_low_level - 8'd1;
            end else begin
                top_extra = 1'b1;
                duty      = LEVEL_TOP;
            end
        endfunction

        function void start_hold();
            phase     = PH_HOLD;
            count     = '0;
            top_extra = 1'b0;
            if (regs.hold_ticks == '0)
                start_return();
        endfunction

        function void start_pause();
            logic [TICKS_W-1:0] units;
            units      = TICKS_W'(shift_lfsr() % PAUSE_MOD);
            phase      = PH_PAUSE;
            count      = '0;
            top_extra  = 1'b0;
            units_left = units;
            if (units == '0 || regs.pause_unit_ticks == '0)
                start_rise();
        endfunction

        // Move one level along the current ramp, or leave it at its end
        function void end_of_step();
            count = '0;
            if (phase == PH_RISE) begin
                if (regs.alt_mode) begin
                    if (duty <= regs.alt_low_level) start_hold();
                    else duty = duty - 8'd1;
                end else begin
                    if (duty == LEVEL_TOP) start_hold();
                    else duty = duty + 8'd1;
                end
            end else if (regs.alt_mode) begin
                if (duty == LEVEL_ALT_TOP) start_pause();
                else duty = duty + 8'd1;
            end else if (top_extra) begin
                top_extra = 1'b0;
                duty      = LEVEL_TOP;
            end else begin
                if (duty <= regs.low_level) start_pause();
                else duty = duty - 8'd1;
            end
        endfunction

        function void advance_tick();
            logic [TICKS_W-1:0] step;
            step  = (regs.step_ticks == '0) ? TICKS_W'(1) : regs.step_ticks;
            count = count + 1'b1;
            case (phase)
                PH_RISE, PH_RETURN: begin
                    if (count >= step)
                        end_of_step();
                end
                PH_HOLD: begin
                    if (count >= regs.hold_ticks)
                        start_return();
                end
                default: begin
                    if (regs.pause_unit_ticks == '0 || units_left == '0) begin
                        start_rise();
                    end else if (count >= regs.pause_unit_ticks) begin
                        count      = '0;
                        units_left = units_left - 1'b1;
                        if (units_left == '0)
                            start_rise();
                    end
                end
            endcase
        endfunction

        // Note an accepted tick word and queue the level it must produce
        function void note_tick(input logic tick);
            t_level_word w;
            if (tick)
                advance_tick();
            w.duty  = duty;
            w.phase = phase;
            expected_levels.push_back(w);
        endfunction

        // Compare a result word with the oldest queued level
        function void check_word(input logic [LEVEL_W-1:0] got_duty,
                                 input logic [1:0] got_phase);
            t_level_word w;
            if (expected_levels.size() == 0) begin
                failures++;
                $display("%0t: unexpected result word: duty %0d phase %0d",
                         $time, got_duty, got_phase);
                return;
            end
            w = expected_levels.pop_front();
            if (got_duty !== w.duty) begin
                failures++;
                $display("%0t: duty mismatch: expected %0d, actual %0d",
                         $time, w.duty, got_duty);
            end
            if (got_phase !== w.phase) begin
                failures++;
                $display("%0t: phase mismatch: expected %0d, actual %0d",
                         $time, w.phase, got_phase);
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

endpackage

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the LED flicker sequencer unit.
// ----------------------------------------------------------------------------
// Tick words go in through bursts with random gaps while the result side
// stalls on a pattern of its own. A short directed run covers idle ticks and
// zero-length step, hold and pause; then the block runs under extreme and
// random register settings, reprogrammed only once every result has come.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::*;
    import flicker_sb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_tick      = 1'b0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [LEVEL_W-1:0]    o_duty;
    logic [1:0]            o_phase;

    flicker_scoreboard flicker;
    int                cycle_count = 0;
    int                burst_left  = 0;
    t_stall_mode       stall_mode  = STALL_NONE;
    int                stall_left  = 0;

    led_flicker_sequencer_unit #(
        .PAUSE_MODULUS (PAUSE_MOD)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_tick      (i_tick),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_duty      (o_duty),
        .o_phase     (o_phase),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Count cycles and drop out on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the result side in stretches of changing character
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= (cycle_count % 3 == 0);
        endcase
    end

    // Check every result word taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            flicker.check_word(o_duty, o_phase);
    end

    // Offer one tick word, hold it until taken, then maybe open a gap
    task automatic send_tick(input logic tick);
        int gap;
        i_valid <= 1'b1;
        i_tick  <= tick;
        do @(posedge i_clk); while (o_stall);
        flicker.note_tick(tick);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic run_ticks(input int count);
        for (int k = 0; k < count; k++)
            send_tick(1'($urandom_range(0, 99) < 85));
    endtask

    // Stop sending and wait until every queued level has come back
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (flicker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        flicker.write_reg(idx, data);
    endtask

    // Write all registers; with noise set, fill unused bits and spare indexes
    task automatic apply_settings(input t_cfg s, input bit noisy);
        logic [CFG_DATA_W-1:0] noise;
        noise = noisy ? CFG_DATA_W'($urandom) : '0;
        put_reg(CFG_ALT_MODE, {noise[CFG_DATA_W-1:1], s.alt_mode});
        put_reg(CFG_LOW_LEVEL, {noise[CFG_DATA_W-1:LEVEL_W], s.low_level});
        put_reg(CFG_ALT_LOW_LEVEL, {noise[CFG_DATA_W-1:LEVEL_W], s.alt_low_level});
        put_reg(CFG_STEP_TICKS, s.step_ticks);
        put_reg(CFG_HOLD_TICKS, s.hold_ticks);
        put_reg(CFG_PAUSE_UNIT, s.pause_unit_ticks);
        if (noisy) begin
            put_reg(CFG_SPARE_LO, noise);
            put_reg(CFG_SPARE_HI, ~noise);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Favor short ramps, holds and pauses so that many loops complete
    function automatic t_cfg pick_settings();
        t_cfg s;
        s.alt_mode = 1'($urandom_range(0, 1));
        s.low_level = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(224, 255))
                                                  : 8'($urandom);
        s.alt_low_level = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(224, 255))
                                                      : 8'($urandom);
        s.step_ticks = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 3))
                                                   : 16'($urandom_range(4, 24));
        s.hold_ticks = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 6))
                                                   : 16'($urandom_range(7, 40));
        s.pause_unit_ticks = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 2))
                                                         : 16'($urandom_range(3, 12));
        return s;
    endfunction

    initial begin
        flicker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, with an idle word among the ticks
        for (int k = 0; k < 5; k++)
            send_tick(1'(k != 1));
        wait_drain();

        // Zero step, hold and pause: the whole loop turns in two ticks
        apply_settings('{alt_mode: 1'b1, low_level: 8'd250, alt_low_level: 8'd255,
                         step_ticks: 16'd0, hold_ticks: 16'd0,
                         pause_unit_ticks: 16'd0}, 1'b0);
        for (int k = 0; k < 10; k++)
            send_tick(1'(k % 4 != 3));
        wait_drain();

        // Short hold and single-tick pause units
        apply_settings('{alt_mode: 1'b1, low_level: 8'd250, alt_low_level: 8'd255,
                         step_ticks: 16'd0, hold_ticks: 16'd2,
                         pause_unit_ticks: 16'd1}, 1'b0);
        for (int k = 0; k < 10; k++)
            send_tick(1'b1);
        wait_drain();

        // Lowest levels, full-length ramps
        apply_settings('{alt_mode: 1'b0, low_level: 8'd0, alt_low_level: 8'd0,
                         step_ticks: 16'd0, hold_ticks: 16'd0,
                         pause_unit_ticks: 16'd0}, 1'b0);
        run_ticks(250);
        wait_drain();

        // Alternate mode down to zero, so the return ramp wraps past 255
        apply_settings('{alt_mode: 1'b1, low_level: 8'd255, alt_low_level: 8'd0,
                         step_ticks: 16'd0, hold_ticks: 16'd0,
                         pause_unit_ticks: 16'd1}, 1'b1);
        run_ticks(300);
        wait_drain();

        // Largest counts everywhere
        apply_settings('{alt_mode: 1'b0, low_level: 8'd255, alt_low_level: 8'd255,
                         step_ticks: 16'hFFFF, hold_ticks: 16'hFFFF,
                         pause_unit_ticks: 16'hFFFF}, 1'b0);
        run_ticks(40);
        wait_drain();

        apply_settings('{alt_mode: 1'b1, low_level: 8'd255, alt_low_level: 8'd255,
                         step_ticks: 16'd1, hold_ticks: 16'hFFFF,
                         pause_unit_ticks: 16'hFFFF}, 1'b1);
        run_ticks(40);
        wait_drain();

        // Random settings, each picked up mid-sequence
        for (int p = 0; p < 10; p++) begin
            apply_settings(pick_settings(), 1'($urandom_range(0, 2) == 0));
            run_ticks(60);
            if (p == 3)
                wait_drain();
            run_ticks(60);
            wait_drain();
        end

        if (flicker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
